// ===== rtl/hsvb_pkg.sv =====
`default_nettype none

package hsvb_pkg;

    // one 8-bit colour channel or HSV component
    typedef logic [7:0] chan_t;

    // hue sector codes, six sectors; the first five hold 43 hue steps each and the last holds 41
    typedef enum logic [2:0] {
        REGION_0 = 3'd0,
        REGION_1 = 3'd1,
        REGION_2 = 3'd2,
        REGION_3 = 3'd3,
        REGION_4 = 3'd4,
        REGION_5 = 3'd5
    } region_t;

    localparam int unsigned HUE_REGION_SIZE = 43;
    localparam int unsigned FULL_SCALE      = 255;
    localparam int unsigned PERCENT_FULL    = 100;
    localparam int unsigned PCT_W           = 7;

    // reciprocal of 100 in 19 fractional bits; exact for products up to 25500
    localparam int unsigned RECIP_100       = 5243;
    localparam int unsigned RECIP_100_SHIFT = 19;

    // brightness floor from a percent register value, clamped to full scale
    function automatic chan_t floor_of_percent(input logic [PCT_W-1:0] pct);
        logic [PCT_W-1:0] pct_sat;
        logic [14:0]      scaled;
        logic [27:0]      prod;
        pct_sat = (pct > PCT_W'(PERCENT_FULL)) ? PCT_W'(PERCENT_FULL) : pct;
        scaled  = (15'(pct_sat) << 8) - 15'(pct_sat);
        prod    = 28'(scaled) * 28'(RECIP_100);
        return chan_t'(prod >> RECIP_100_SHIFT);
    endfunction

    // truncating divide by 255, exact for inputs up to 255*255
    function automatic chan_t div_255(input logic [15:0] y);
        logic [16:0] s;
        s = 17'(y) + 17'(y[15:8]) + 17'd1;
        return chan_t'(s >> 8);
    endfunction

    // hue sector by comparison against the sector boundaries
    function automatic region_t hue_region(input chan_t hue);
        region_t r;
        if (hue < 8'(HUE_REGION_SIZE))          r = REGION_0;
        else if (hue < 8'(2*HUE_REGION_SIZE))   r = REGION_1;
        else if (hue < 8'(3*HUE_REGION_SIZE))   r = REGION_2;
        else if (hue < 8'(4*HUE_REGION_SIZE))   r = REGION_3;
        else if (hue < 8'(5*HUE_REGION_SIZE))   r = REGION_4;
        else                                    r = REGION_5;
        return r;
    endfunction

    // first hue step of a sector
    function automatic chan_t region_base(input region_t r);
        chan_t b;
        case (r)
            REGION_0: b = 8'd0;
            REGION_1: b = 8'(HUE_REGION_SIZE);
            REGION_2: b = 8'(2*HUE_REGION_SIZE);
            REGION_3: b = 8'(3*HUE_REGION_SIZE);
            REGION_4: b = 8'(4*HUE_REGION_SIZE);
            default:  b = 8'(5*HUE_REGION_SIZE);
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hsvb_hsv_if.sv =====
`default_nettype none

// HSV request channel
interface hsvb_hsv_if import hsvb_pkg::*; ();
    logic  valid;
    logic  ready;
    chan_t hue;
    chan_t saturation;
    chan_t brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/hsvb_rgb_if.sv =====
`default_nettype none

// RGB result channel
interface hsvb_rgb_if import hsvb_pkg::*; ();
    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/hsv_to_rgb_min_brightness.sv =====
`default_nettype none

// HSV to RGB converter with a brightness floor, 8 bits per channel. One request
// is taken every clock cycle while the output is not stalled; its RGB result is
// held in an output register. There are four register stages: sector split and
// floor product, value and hue-fraction products, the three p/q/t products, and
// channel select. Each of the first three holds one multiplier level. Each stage
// moves on whenever the stage after it is empty or moving, so a stall at the
// output fills bubbles and loses nothing. The floor is worked out from cfg_wr_data
// when the register is written (values above 100 act as 100); write it only while
// no request is in flight.
module hsv_to_rgb_min_brightness import hsvb_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [PCT_W-1:0] cfg_wr_data,
    hsvb_hsv_if.sink              hsv,
    hsvb_rgb_if.source            rgb
);

    // brightness floor, held in its final form
    chan_t floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            floor_reg <= floor_of_percent(cfg_wr_data);
        end
    end

    // stage valids and advance terms
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4      = !s4_valid_reg || rgb.ready;
    assign adv3      = !s3_valid_reg || adv4;
    assign adv2      = !s2_valid_reg || adv3;
    assign adv1      = !s1_valid_reg || adv2;
    assign hsv.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1) s1_valid_reg <= hsv.valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
            if (adv3) s3_valid_reg <= s2_valid_reg;
            if (adv4) s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: hue sector and remainder, brightness times headroom
    region_t     s1_region_next, s1_region_reg;
    chan_t       s1_rem6_next, s1_rem6_reg;
    chan_t       s1_sat_reg;
    logic        s1_black_reg;
    logic [15:0] s1_prod_next, s1_prod_reg;
    logic [5:0]  s1_rem;

    always_comb
    begin
        s1_region_next = hue_region(hsv.hue);
        s1_rem         = 6'(hsv.hue - region_base(s1_region_next));
        s1_rem6_next   = (8'(s1_rem) << 2) + (8'(s1_rem) << 1);
        s1_prod_next   = 16'(hsv.brightness) * 16'(8'(FULL_SCALE) - floor_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && hsv.valid)
        begin
            s1_region_reg <= s1_region_next;
            s1_rem6_reg   <= s1_rem6_next;
            s1_sat_reg    <= hsv.saturation;
            s1_black_reg  <= (hsv.brightness == 8'd0);
            s1_prod_reg   <= s1_prod_next;
        end
    end

    // stage 2: lifted value, saturation times hue fraction and its complement
    chan_t       s2_v_next, s2_v_reg;
    logic [15:0] s2_ps_next, s2_ps_reg;
    logic [15:0] s2_pt_next, s2_pt_reg;
    region_t     s2_region_reg;
    chan_t       s2_sat_reg;
    logic        s2_black_reg;

    always_comb
    begin
        s2_v_next  = floor_reg + div_255(s1_prod_reg);
        s2_ps_next = 16'(s1_sat_reg) * 16'(s1_rem6_reg);
        s2_pt_next = 16'(s1_sat_reg) * 16'(8'(FULL_SCALE) - s1_rem6_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            s2_v_reg      <= s2_v_next;
            s2_ps_reg     <= s2_ps_next;
            s2_pt_reg     <= s2_pt_next;
            s2_region_reg <= s1_region_reg;
            s2_sat_reg    <= s1_sat_reg;
            s2_black_reg  <= s1_black_reg;
        end
    end

    // stage 3: p, q and t products
    logic [15:0] s3_pp_next, s3_pp_reg;
    logic [15:0] s3_pq_next, s3_pq_reg;
    logic [15:0] s3_ptt_next, s3_ptt_reg;
    chan_t       s3_v_reg;
    region_t     s3_region_reg;
    logic        s3_black_reg;
    logic        s3_grey_reg;
    chan_t       s2_kq, s2_kt;

    always_comb
    begin
        s2_kq       = chan_t'(s2_ps_reg >> 8);
        s2_kt       = chan_t'(s2_pt_reg >> 8);
        s3_pp_next  = 16'(s2_v_reg) * 16'(8'(FULL_SCALE) - s2_sat_reg);
        s3_pq_next  = 16'(s2_v_reg) * 16'(8'(FULL_SCALE) - s2_kq);
        s3_ptt_next = 16'(s2_v_reg) * 16'(8'(FULL_SCALE) - s2_kt);
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid_reg)
        begin
            s3_pp_reg     <= s3_pp_next;
            s3_pq_reg     <= s3_pq_next;
            s3_ptt_reg    <= s3_ptt_next;
            s3_v_reg      <= s2_v_reg;
            s3_region_reg <= s2_region_reg;
            s3_black_reg  <= s2_black_reg;
            s3_grey_reg   <= (s2_sat_reg == 8'd0);
        end
    end

    // stage 4: channel select into the output register
    chan_t p, q, t, v;
    chan_t r_next, g_next, b_next;
    chan_t red_reg, green_reg, blue_reg;

    always_comb
    begin
        p = chan_t'(s3_pp_reg >> 8);
        q = chan_t'(s3_pq_reg >> 8);
        t = chan_t'(s3_ptt_reg >> 8);
        v = s3_v_reg;
        if (s3_black_reg)
        begin
            r_next = '0;
            g_next = '0;
            b_next = '0;
        end
        else if (s3_grey_reg)
        begin
            r_next = v;
            g_next = v;
            b_next = v;
        end
        else
        begin
            case (s3_region_reg)
                REGION_0: begin r_next = v; g_next = t; b_next = p; end
                REGION_1: begin r_next = q; g_next = v; b_next = p; end
                REGION_2: begin r_next = p; g_next = v; b_next = t; end
                REGION_3: begin r_next = p; g_next = q; b_next = v; end
                REGION_4: begin r_next = t; g_next = p; b_next = v; end
                default:  begin r_next = v; g_next = p; b_next = q; end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4 && s3_valid_reg)
        begin
            red_reg   <= r_next;
            green_reg <= g_next;
            blue_reg  <= b_next;
        end
    end

    assign rgb.valid = s4_valid_reg;
    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

endmodule

`default_nettype wire

// ===== rtl/hsvb_checker.sv =====
`default_nettype none

// port-level checks on the converter
module hsvb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue
);

    localparam logic [2:0] DEPTH = 3'd4;

    // requests taken but not yet delivered
    logic [2:0] inflight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 3'(in_valid && in_ready)
                                         - 3'(out_valid && out_ready);
        end
    end

    // a stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
                                    && $stable(blue))
        else $error("stalled result changed");

    // never more requests in flight than pipeline stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= DEPTH)
        else $error("more requests in flight than stages");

    // no result without a request behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == 3'd0 |-> !out_valid)
        else $error("result with nothing in flight");

    // an empty pipeline takes a request
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == 3'd0 |-> in_ready)
        else $error("empty pipeline refuses requests");

endmodule

bind hsv_to_rgb_min_brightness hsvb_checker u_hsvb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hsv.valid),
    .in_ready  (hsv.ready),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .red       (rgb.red),
    .green     (rgb.green),
    .blue      (rgb.blue)
);

`default_nettype wire
